>>> hdl/dafp_pkg.sv
// dafp_pkg: shared constants, register codes, lane state type and the
// control/result structs of the dual-axis filtered PID.
// No dependencies.
package dafp_pkg;

	// Drive limit, +-11 degrees in Q1.15 radians
	localparam int OUTPUT_LIMIT = 6291;

	localparam int CFG_AW    = 5;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 25;
	localparam int DIV_CNT_W = 7;
	localparam int COEF_W    = 44;
	localparam int ERR_W     = 17;
	localparam int HIST_W    = 48;
	localparam int DRIVE_W   = 14;

	typedef enum logic [2:0] {
		REG_PROP_X,
		REG_INTEG_X,
		REG_DERIV_X,
		REG_PROP_Y,
		REG_INTEG_Y,
		REG_DERIV_Y,
		REG_FILTER_N,
		REG_SAMPLE_PERIOD
	} dafp_reg_t;

	typedef enum logic [3:0] {
		L_IDLE,
		L_NT,
		L_PREP,
		L_GO0,
		L_W0,
		L_GO1,
		L_W1,
		L_GO2,
		L_W2,
		L_UPD,
		L_GOF,
		L_MAC,
		L_WF,
		L_SUM,
		L_RND,
		L_DONE
	} dafp_lane_st_t;

	typedef struct packed {
		logic start;
		logic ack;
		logic cfg_wr;
	} dafp_ctl_t;

	typedef struct packed {
		logic                        done;
		logic                        clamped;
		logic signed [DRIVE_W-1:0]   drive;
	} dafp_res_t;

endpackage

>>> hdl/dafp_div.sv
// dafp_div: iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on dafp_pkg for widths.
module dafp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [dafp_pkg::DIV_NUM_W-1:0]     dividend,
	input  logic [dafp_pkg::DIV_DEN_W-1:0]     divisor,
	output logic                               busy,
	output logic [dafp_pkg::DIV_NUM_W-1:0]     quotient
);

	logic [dafp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dafp_pkg::DIV_NUM_W-1:0] dvd_q;
	logic [dafp_pkg::DIV_DEN_W-1:0] rem_q;
	logic [dafp_pkg::DIV_DEN_W-1:0] den_q;
	logic [dafp_pkg::DIV_DEN_W:0]   shifted;
	logic [dafp_pkg::DIV_DEN_W:0]   trial;
	logic                           fits;

	assign shifted  = {rem_q, dvd_q[dafp_pkg::DIV_NUM_W-1]};
	assign trial    = shifted - {1'b0, den_q};
	assign fits     = !trial[dafp_pkg::DIV_DEN_W];
	assign busy     = (cnt_q != '0);
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= dafp_pkg::DIV_CNT_W'(dafp_pkg::DIV_NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? trial[dafp_pkg::DIV_DEN_W-1:0] : shifted[dafp_pkg::DIV_DEN_W-1:0];
			dvd_q <= {dvd_q[dafp_pkg::DIV_NUM_W-2:0], fits};
		end
	end

endmodule

>>> hdl/dafp_lane.sv
// dafp_lane: one axis of the filtered PID; coefficient build, history,
// multiply-accumulate, filter division, saturation, rounding and clamp.
// Depends on dafp_pkg and dafp_div.
module dafp_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dafp_pkg::dafp_ctl_t                  ctl,
	input  logic signed [31:0]                   kp,
	input  logic signed [31:0]                   ki,
	input  logic signed [31:0]                   kd,
	input  logic [7:0]                           filter_n,
	input  logic [15:0]                          sample_period,
	input  logic signed [dafp_pkg::ERR_W-1:0]    err,
	output dafp_pkg::dafp_res_t                  res
);

	localparam logic signed [63:0] U_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] U_MIN = -64'sh0000_8000_0000_0000;
	localparam logic signed [48:0] LIM   = 49'(dafp_pkg::OUTPUT_LIMIT);

	dafp_pkg::dafp_lane_st_t state_q, state_d;

	logic                                    coef_ok_q;
	logic signed [dafp_pkg::ERR_W-1:0]       e0_q, e1_q, e2_q;
	logic signed [dafp_pkg::HIST_W-1:0]      u1_q, u2_q;
	logic [23:0]                             nt_q;
	logic signed [39:0]                      kdn40_q;
	logic signed [47:0]                      kits_q;
	logic [dafp_pkg::DIV_DEN_W-1:0]          a_q;
	logic signed [57:0]                      kpm_q;
	logic signed [dafp_pkg::COEF_W-1:0]      p0_q, ce0_q, ce1_q, ce2_q;
	logic signed [64:0]                      num_q;
	logic [2:0]                              mac_cnt_q;
	logic signed [63:0]                      prod_q, acc_q;
	logic signed [48:0]                      filt_q;
	logic signed [dafp_pkg::DRIVE_W-1:0]     drive_q;
	logic                                    clamp_q;

	logic                                    div_start, div_busy;
	logic [dafp_pkg::DIV_NUM_W-1:0]          div_quo, num_mag;
	logic signed [64:0]                      num_neg, quo_s, quo_n, kdn_w;
	logic signed [64:0]                      ce1_num, ce2_num, d_num;
	logic signed [40:0]                      kdn_p;
	logic signed [48:0]                      kits_p;
	logic [25:0]                             k2_w;
	logic signed [58:0]                      kpm_p;
	logic signed [47:0]                      kits_adj, kits_sh;
	logic signed [dafp_pkg::COEF_W-1:0]      mac_coef;
	logic signed [dafp_pkg::ERR_W-1:0]       mac_e;
	logic signed [22:0]                      mac_a;
	logic signed [39:0]                      mac_p;
	logic signed [63:0]                      mac_ext, total;
	logic signed [dafp_pkg::HIST_W-1:0]      u0_sat;
	logic signed [48:0]                      rnd, v;

	// signed division through magnitudes; divisor is always positive
	assign num_neg = -num_q;
	assign num_mag = num_q[64] ? num_neg[63:0] : num_q[63:0];
	assign quo_s   = num_q[64] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign quo_n   = -quo_s;

	dafp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (a_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// coefficient terms
	assign kdn_p    = kd * $signed({1'b0, filter_n});
	assign kits_p   = ki * $signed({1'b0, sample_period});
	assign k2_w     = 26'd131072 + {2'b00, nt_q};
	assign kpm_p    = kp * $signed({1'b0, k2_w});
	assign kits_adj = kits_q + (kits_q[47] ? 48'sd65535 : 48'sd0);
	assign kits_sh  = kits_adj >>> 16;
	assign kdn_w    = {{9{kdn40_q[39]}}, kdn40_q, 16'b0};
	assign ce1_num  = {{7{kpm_q[57]}}, kpm_q} + {{17{kits_q[47]}}, kits_q} + (kdn_w <<< 1);
	assign ce2_num  = {{17{kp[31]}}, kp, 16'b0} + kdn_w;
	assign d_num    = ({{17{u1_q[47]}}, u1_q} - {{17{u2_q[47]}}, u2_q}) <<< 16;

	// MAC operand select: coefficient halves times error
	always_comb begin
		unique case (mac_cnt_q[2:1])
			2'd1: begin
				mac_coef = ce1_q;
				mac_e    = e1_q;
			end
			2'd2: begin
				mac_coef = ce2_q;
				mac_e    = e2_q;
			end
			default: begin
				mac_coef = ce0_q;
				mac_e    = e0_q;
			end
		endcase
	end

	assign mac_a   = mac_cnt_q[0] ? {mac_coef[43], mac_coef[43:22]} : {1'b0, mac_coef[21:0]};
	assign mac_p   = mac_a * mac_e;
	assign mac_ext = mac_cnt_q[0] ? {{2{mac_p[39]}}, mac_p, 22'b0} : {{24{mac_p[39]}}, mac_p};

	assign total  = acc_q + {{15{filt_q[48]}}, filt_q} + {{16{u1_q[47]}}, u1_q};
	always_comb begin
		priority if (total > U_MAX) begin
			u0_sat = U_MAX[47:0];
		end else if (total < U_MIN) begin
			u0_sat = U_MIN[47:0];
		end else begin
			u0_sat = total[47:0];
		end
	end

	assign rnd = {u1_q[47], u1_q} + 49'sd2048;
	assign v   = rnd >>> 12;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dafp_pkg::L_IDLE:
				if (ctl.start) state_d = coef_ok_q ? dafp_pkg::L_UPD : dafp_pkg::L_NT;
			dafp_pkg::L_NT:   state_d = dafp_pkg::L_PREP;
			dafp_pkg::L_PREP: state_d = dafp_pkg::L_GO0;
			dafp_pkg::L_GO0:  state_d = dafp_pkg::L_W0;
			dafp_pkg::L_W0:   if (!div_busy) state_d = dafp_pkg::L_GO1;
			dafp_pkg::L_GO1:  state_d = dafp_pkg::L_W1;
			dafp_pkg::L_W1:   if (!div_busy) state_d = dafp_pkg::L_GO2;
			dafp_pkg::L_GO2:  state_d = dafp_pkg::L_W2;
			dafp_pkg::L_W2:   if (!div_busy) state_d = dafp_pkg::L_UPD;
			dafp_pkg::L_UPD:  state_d = dafp_pkg::L_GOF;
			dafp_pkg::L_GOF:  state_d = dafp_pkg::L_MAC;
			dafp_pkg::L_MAC:  if (mac_cnt_q == 3'd6) state_d = dafp_pkg::L_WF;
			dafp_pkg::L_WF:   if (!div_busy) state_d = dafp_pkg::L_SUM;
			dafp_pkg::L_SUM:  state_d = dafp_pkg::L_RND;
			dafp_pkg::L_RND:  state_d = dafp_pkg::L_DONE;
			dafp_pkg::L_DONE: if (ctl.ack) state_d = dafp_pkg::L_IDLE;
			default: state_d = dafp_pkg::L_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		unique case (state_q)
			dafp_pkg::L_GO0, dafp_pkg::L_GO1, dafp_pkg::L_GO2,
			dafp_pkg::L_GOF: div_start = 1'b1;
			default:         div_start = 1'b0;
		endcase
		res.done    = (state_q == dafp_pkg::L_DONE);
		res.clamped = clamp_q;
		res.drive   = drive_q;
	end

	// control and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dafp_pkg::L_IDLE;
			coef_ok_q <= 1'b0;
			mac_cnt_q <= '0;
			e1_q      <= '0;
			e2_q      <= '0;
			u1_q      <= '0;
			u2_q      <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.cfg_wr) begin
				coef_ok_q <= 1'b0;
			end else if (state_q == dafp_pkg::L_W2 && !div_busy) begin
				coef_ok_q <= 1'b1;
			end
			if (state_q == dafp_pkg::L_UPD) begin
				mac_cnt_q <= '0;
			end else if (state_q == dafp_pkg::L_MAC) begin
				mac_cnt_q <= mac_cnt_q + 1'b1;
			end
			if (state_q == dafp_pkg::L_SUM) begin
				e2_q <= e1_q;
				e1_q <= e0_q;
				u2_q <= u1_q;
				u1_q <= u0_sat;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			dafp_pkg::L_IDLE: if (ctl.start) e0_q <= err;
			dafp_pkg::L_NT: begin
				nt_q    <= filter_n * sample_period;
				kdn40_q <= kdn_p[39:0];
				kits_q  <= kits_p[47:0];
			end
			dafp_pkg::L_PREP: begin
				a_q   <= 25'd65536 + {1'b0, nt_q};
				kpm_q <= kpm_p[57:0];
				p0_q  <= {{12{kp[31]}}, kp} + kits_sh[43:0];
				num_q <= kdn_w;
			end
			dafp_pkg::L_W0: if (!div_busy) begin
				ce0_q <= p0_q + quo_s[43:0];
				num_q <= ce1_num;
			end
			dafp_pkg::L_W1: if (!div_busy) begin
				ce1_q <= quo_n[43:0];
				num_q <= ce2_num;
			end
			dafp_pkg::L_W2: if (!div_busy) ce2_q <= quo_s[43:0];
			dafp_pkg::L_UPD: begin
				num_q <= d_num;
				acc_q <= '0;
			end
			dafp_pkg::L_MAC: begin
				if (mac_cnt_q != 3'd6) prod_q <= mac_ext;
				if (mac_cnt_q != 3'd0) acc_q <= acc_q + prod_q;
			end
			dafp_pkg::L_WF: if (!div_busy) filt_q <= quo_s[48:0];
			dafp_pkg::L_RND: begin
				priority if (v > LIM) begin
					drive_q <= LIM[13:0];
					clamp_q <= 1'b1;
				end else if (v < -LIM) begin
					drive_q <= -LIM[13:0];
					clamp_q <= 1'b1;
				end else begin
					drive_q <= v[13:0];
					clamp_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/dual_axis_filtered_pid.sv
// Each request runs the filter division in each lane; after reset or a configuration write
// the first request also rebuilds the coefficients, with three divisions per lane first.
// One request is in flight at a time: in_stall holds off a new one until both lane results load.
// A new request is taken while a result in the output register still waits on out_stall.
// Reset (arst_n low, asynchronous): registers to defaults, history and handshake cleared.
module dual_axis_filtered_pid (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB-style configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dafp_pkg::CFG_AW-1:0]           paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [15:0]                    estimate_x,
	input  logic signed [15:0]                    estimate_y,
	input  logic signed [15:0]                    setpoint_x,
	input  logic signed [15:0]                    setpoint_y,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dafp_pkg::DRIVE_W-1:0]   drive_x,
	output logic signed [dafp_pkg::DRIVE_W-1:0]   drive_y,
	output logic                                  clamped_x,
	output logic                                  clamped_y
);

	logic signed [31:0] kp_x_q, ki_x_q, kd_x_q, kp_y_q, ki_y_q, kd_y_q;
	logic [7:0]         filter_n_q;
	logic [15:0]        sample_period_q;

	logic                cfg_we, accept, both_done, load;
	logic                busy_q, out_valid_q;
	dafp_pkg::dafp_reg_t reg_sel;
	dafp_pkg::dafp_ctl_t ctl;
	dafp_pkg::dafp_res_t res_x, res_y;
	logic signed [dafp_pkg::ERR_W-1:0] err_x, err_y;

	logic signed [dafp_pkg::DRIVE_W-1:0] drive_x_q, drive_y_q;
	logic                                clamped_x_q, clamped_y_q;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign reg_sel = dafp_pkg::dafp_reg_t'(paddr[4:2]);

	// register readback
	always_comb begin
		unique case (reg_sel)
			dafp_pkg::REG_PROP_X:        prdata = kp_x_q;
			dafp_pkg::REG_INTEG_X:       prdata = ki_x_q;
			dafp_pkg::REG_DERIV_X:       prdata = kd_x_q;
			dafp_pkg::REG_PROP_Y:        prdata = kp_y_q;
			dafp_pkg::REG_INTEG_Y:       prdata = ki_y_q;
			dafp_pkg::REG_DERIV_Y:       prdata = kd_y_q;
			dafp_pkg::REG_FILTER_N:      prdata = {24'b0, filter_n_q};
			dafp_pkg::REG_SAMPLE_PERIOD: prdata = {16'b0, sample_period_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_x_q          <= -32'sd67109;
			ki_x_q          <= -32'sd13422;
			kd_x_q          <= -32'sd80531;
			kp_y_q          <= -32'sd80531;
			ki_y_q          <= -32'sd26844;
			kd_y_q          <= -32'sd67109;
			filter_n_q      <= 8'd20;
			sample_period_q <= 16'd655;
		end else if (cfg_we) begin
			unique case (reg_sel)
				dafp_pkg::REG_PROP_X:        kp_x_q          <= pwdata;
				dafp_pkg::REG_INTEG_X:       ki_x_q          <= pwdata;
				dafp_pkg::REG_DERIV_X:       kd_x_q          <= pwdata;
				dafp_pkg::REG_PROP_Y:        kp_y_q          <= pwdata;
				dafp_pkg::REG_INTEG_Y:       ki_y_q          <= pwdata;
				dafp_pkg::REG_DERIV_Y:       kd_y_q          <= pwdata;
				dafp_pkg::REG_FILTER_N:      filter_n_q      <= pwdata[7:0];
				dafp_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// one request in flight; the lanes run in lockstep
	assign in_stall  = busy_q;
	assign accept    = in_valid & !busy_q;
	assign both_done = res_x.done & res_y.done;
	assign load      = both_done & (!out_valid_q | !out_stall);

	assign ctl.start  = accept;
	assign ctl.ack    = load;
	assign ctl.cfg_wr = cfg_we;

	// error = estimate - setpoint, 17 bits
	assign err_x = {estimate_x[15], estimate_x} - {setpoint_x[15], setpoint_x};
	assign err_y = {estimate_y[15], estimate_y} - {setpoint_y[15], setpoint_y};

	dafp_lane u_lane_x (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.kp            (kp_x_q),
		.ki            (ki_x_q),
		.kd            (kd_x_q),
		.filter_n      (filter_n_q),
		.sample_period (sample_period_q),
		.err           (err_x),
		.res           (res_x)
	);

	dafp_lane u_lane_y (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.kp            (kp_y_q),
		.ki            (ki_y_q),
		.kd            (kd_y_q),
		.filter_n      (filter_n_q),
		.sample_period (sample_period_q),
		.err           (err_y),
		.res           (res_y)
	);

	// merge: both lane results go to the output register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drive_x_q   <= res_x.drive;
			drive_y_q   <= res_y.drive;
			clamped_x_q <= res_x.clamped;
			clamped_y_q <= res_y.clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_x   = drive_x_q;
	assign drive_y   = drive_y_q;
	assign clamped_x = clamped_x_q;
	assign clamped_y = clamped_y_q;

	// lanes share one schedule, so they must finish together
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		res_x.done == res_y.done)
		else $error("lane done flags diverged");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result loaded without a request in flight");

	a_range_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_x_q <= dafp_pkg::OUTPUT_LIMIT &&
			drive_x_q >= -dafp_pkg::OUTPUT_LIMIT))
		else $error("drive_x beyond limit");

	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clamped_x_q) |-> (drive_x_q == dafp_pkg::OUTPUT_LIMIT ||
			drive_x_q == -dafp_pkg::OUTPUT_LIMIT))
		else $error("clamped_x set with drive inside limit");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clamped_y_q) |-> (drive_y_q == dafp_pkg::OUTPUT_LIMIT ||
			drive_y_q == -dafp_pkg::OUTPUT_LIMIT))
		else $error("clamped_y set with drive inside limit");

endmodule
